// ===== rtl/nand_block_remapper_defines.svh =====
// ----------------------------------------------------------------------------
// nand_block_remapper_defines: assertion macros shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef NAND_BLOCK_REMAPPER_DEFINES_SVH
`define NAND_BLOCK_REMAPPER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NBR_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nbr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NBR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nbr assertion failed");

`endif

// ===== rtl/nbr_pkg.sv =====
// ----------------------------------------------------------------------------
// nbr_pkg
// Types and constants of the NAND block remapper.
// ----------------------------------------------------------------------------
`default_nettype none

package nbr_pkg;

    localparam int TOTAL_BLOCKS  = 1024;
    localparam int USABLE_BLOCKS = 960;
    localparam int BLOCK_BITS    = 17;
    localparam int PAGE_BITS     = 11;
    localparam int SECTOR_BITS   = 9;

    localparam int BLK_W    = 10;
    localparam int ADDR_W   = 27;
    localparam int SECTOR_W = 18;
    localparam int MARK_W   = 8;
    localparam int PAGE_W   = BLOCK_BITS - PAGE_BITS;
    localparam int LBLK_SHIFT = BLOCK_BITS - SECTOR_BITS;
    localparam int CNT_W    = $clog2(TOTAL_BLOCKS) + 1;
    localparam int MAP_AW   = $clog2(USABLE_BLOCKS);
    localparam int FMT_W    = $clog2(USABLE_BLOCKS + 1);

    localparam logic [1:0] ACT_MARK   = 2'd0;
    localparam logic [1:0] ACT_FORMAT = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;
    localparam logic [1:0] ACT_WRITE  = 2'd3;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_MOVE   = 2'd2;

    localparam logic [1:0] ERR_OK          = 2'd0;
    localparam logic [1:0] ERR_NO_BLOCK    = 2'd1;
    localparam logic [1:0] ERR_RANGE       = 2'd2;
    localparam logic [1:0] ERR_UNFORMATTED = 2'd3;

    typedef struct packed {
        logic [1:0]          action;
        logic [BLK_W-1:0]    block_index;
        logic [MARK_W-1:0]   mark_first;
        logic [MARK_W-1:0]   mark_second;
        logic [SECTOR_W-1:0] sector;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] source_address;
        logic [ADDR_W-1:0] dest_address;
        logic              erase_dest;
        logic              merge_sector;
        logic [1:0]        error;
        logic              last;
    } rsp_word_t;

    typedef struct packed {
        logic       load_in;
        logic       clr_step;
        logic       mark_wr;
        logic       scan_start;
        logic       scan_run;
        logic       scan_fmt;
        logic       scan_srch;
        logic       set_formatted;
        logic       clr_formatted;
        logic       map_rd;
        logic       pg_clear;
        logic       pg_step;
        logic       free_old;
        logic       take_new;
        logic       emit_status;
        logic       emit_read;
        logic       emit_move;
        logic [1:0] err;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic scan_done;
        logic fmt_full;
        logic srch_hit;
        logic range_err;
        logic formatted;
        logic pg_last;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/nbr_cmd_if.sv =====
// ----------------------------------------------------------------------------
// nbr_cmd_if
// Request channel: valid/ready handshake carrying one command word.
// ----------------------------------------------------------------------------
`default_nettype none

interface nbr_cmd_if;
    logic               valid;
    logic               ready;
    nbr_pkg::cmd_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/nbr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// nbr_rsp_if
// Result channel: valid/ready handshake carrying one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface nbr_rsp_if;
    logic               valid;
    logic               ready;
    nbr_pkg::rsp_word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/nbr_datapath.sv =====
// ----------------------------------------------------------------------------
// nbr_datapath
// Block tables, scan pipeline, address generation and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nand_block_remapper_defines.svh"

module nbr_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire nbr_pkg::cmd_word_t cmd_word,
    input  wire nbr_pkg::ctrl_cmd_t ctl,
    output nbr_pkg::dp_stat_t       stat,
    output nbr_pkg::rsp_word_t      rsp_word,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready
);

    localparam int BlkW  = nbr_pkg::BLK_W;
    localparam int CntW  = nbr_pkg::CNT_W;
    localparam int MapAw = nbr_pkg::MAP_AW;
    localparam int FmtW  = nbr_pkg::FMT_W;
    localparam int PageW = nbr_pkg::PAGE_W;
    localparam int PageBits = nbr_pkg::PAGE_BITS;
    localparam int BlockBits = nbr_pkg::BLOCK_BITS;
    localparam int Shift = nbr_pkg::LBLK_SHIFT;
    localparam int SecW = nbr_pkg::SECTOR_W;
    localparam int SecBits = nbr_pkg::SECTOR_BITS;

    logic bad_mem  [nbr_pkg::TOTAL_BLOCKS];
    logic used_mem [nbr_pkg::TOTAL_BLOCKS];
    logic [BlkW-1:0] map_mem [nbr_pkg::USABLE_BLOCKS];

    nbr_pkg::cmd_word_t in_reg;
    nbr_pkg::rsp_word_t rsp_reg, rsp_next;
    logic            rsp_vld_reg, rsp_vld_next;
    logic [CntW-1:0] rd_ptr_reg;
    logic            pipe_vld_reg;
    logic [BlkW-1:0] pipe_addr_reg;
    logic            bad_rd_reg, used_rd_reg;
    logic [FmtW-1:0] fmt_cnt_reg;
    logic            formatted_reg;
    logic [BlkW-1:0] old_blk_reg, new_blk_reg;
    logic [PageW-1:0] page_cnt_reg;

    logic [BlkW-1:0] rd_idx, lblk;
    logic [MapAw-1:0] lblk_idx;
    logic issue, ptr_end, fmt_stage, fmt_take, srch_hit, mark_bad;
    logic bad_we, bad_wd, used_we, used_wd;
    logic [BlkW-1:0] bad_wa, used_wa;
    logic map_we;
    logic [MapAw-1:0] map_wa;
    logic [BlkW-1:0] map_wd;
    logic [BlockBits-1:0] offset, poff;
    logic [PageW-1:0] merge_page;
    logic [nbr_pkg::ADDR_W-1:0] src_base, src_addr;
    logic merge;

    assign rd_idx   = rd_ptr_reg[BlkW-1:0];
    assign ptr_end  = (rd_ptr_reg == CntW'(nbr_pkg::TOTAL_BLOCKS));
    assign issue    = ctl.scan_run && !ptr_end;
    assign lblk     = in_reg.sector[SecW-1:Shift];
    assign lblk_idx = lblk[MapAw-1:0];
    assign mark_bad = ((in_reg.mark_first & in_reg.mark_second) == '0);

    assign fmt_stage = ctl.scan_run && ctl.scan_fmt && pipe_vld_reg;
    assign fmt_take  = fmt_stage && !bad_rd_reg
                       && (fmt_cnt_reg < FmtW'(nbr_pkg::USABLE_BLOCKS));
    assign srch_hit  = pipe_vld_reg && !bad_rd_reg && !used_rd_reg;

    // Bad-block table write port.
    always_comb
    begin
        bad_we = ctl.clr_step || ctl.mark_wr;
        bad_wa = ctl.clr_step ? rd_idx : in_reg.block_index;
        bad_wd = ctl.clr_step ? 1'b0 : mark_bad;
    end

    // Used-block table write port; format rewrites every entry as it scans.
    always_comb
    begin
        used_we = 1'b0;
        used_wa = rd_idx;
        used_wd = 1'b0;
        priority if (ctl.clr_step)
        begin
            used_we = 1'b1;
        end
        else if (fmt_stage)
        begin
            used_we = 1'b1;
            used_wa = pipe_addr_reg;
            used_wd = fmt_take;
        end
        else if (ctl.free_old)
        begin
            used_we = 1'b1;
            used_wa = old_blk_reg;
        end
        else if (ctl.take_new)
        begin
            used_we = 1'b1;
            used_wa = new_blk_reg;
            used_wd = 1'b1;
        end
    end

    always_comb
    begin
        map_we = fmt_take || ctl.take_new;
        map_wa = fmt_take ? fmt_cnt_reg[MapAw-1:0] : lblk_idx;
        map_wd = fmt_take ? pipe_addr_reg : new_blk_reg;
    end

    always_ff @(posedge clk)
    begin
        if (bad_we)
        begin
            bad_mem[bad_wa] <= bad_wd;
        end
        if (used_we)
        begin
            used_mem[used_wa] <= used_wd;
        end
        if (map_we)
        begin
            map_mem[map_wa] <= map_wd;
        end
        bad_rd_reg  <= bad_mem[rd_idx];
        used_rd_reg <= used_mem[rd_idx];
        if (ctl.map_rd)
        begin
            old_blk_reg <= map_mem[lblk_idx];
        end
        if (ctl.load_in)
        begin
            in_reg <= cmd_word;
        end
        pipe_addr_reg <= rd_idx;
        if (ctl.scan_run && ctl.scan_srch && srch_hit)
        begin
            new_blk_reg <= pipe_addr_reg;
        end
        if (rsp_vld_next && !(rsp_vld_reg && !rsp_ready))
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Page move address generation.
    always_comb
    begin
        offset     = {in_reg.sector[Shift-1:0], SecBits'(0)};
        merge_page = in_reg.sector[Shift-1:PageBits-SecBits];
        poff       = {page_cnt_reg, PageBits'(0)};
        src_base   = {old_blk_reg, BlockBits'(0)};
        src_addr   = src_base | {BlkW'(0), offset};
        merge      = (page_cnt_reg == merge_page);
    end

    always_comb
    begin
        rsp_next = '0;
        rsp_next.last = 1'b1;
        rsp_next.error = ctl.err;
        rsp_next.kind = nbr_pkg::KIND_STATUS;
        priority if (ctl.emit_read)
        begin
            rsp_next.kind = nbr_pkg::KIND_READ;
            rsp_next.error = nbr_pkg::ERR_OK;
            rsp_next.source_address = src_addr;
        end
        else if (ctl.emit_move)
        begin
            rsp_next.kind = nbr_pkg::KIND_MOVE;
            rsp_next.error = nbr_pkg::ERR_OK;
            rsp_next.source_address = merge ? src_addr : (src_base | {BlkW'(0), poff});
            rsp_next.dest_address = {new_blk_reg, poff};
            rsp_next.erase_dest = (page_cnt_reg == '0);
            rsp_next.merge_sector = merge;
            rsp_next.last = (page_cnt_reg == '1);
        end
    end

    always_comb
    begin
        rsp_vld_next = ctl.emit_status || ctl.emit_read || ctl.emit_move;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_vld_reg   <= 1'b0;
            rd_ptr_reg    <= '0;
            pipe_vld_reg  <= 1'b0;
            fmt_cnt_reg   <= '0;
            formatted_reg <= 1'b0;
            page_cnt_reg  <= '0;
        end
        else
        begin
            if (rsp_vld_next)
            begin
                rsp_vld_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_vld_reg <= 1'b0;
            end
            if (ctl.scan_start)
            begin
                rd_ptr_reg <= '0;
            end
            else if (issue || (ctl.clr_step && !ptr_end))
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            pipe_vld_reg <= issue;
            if (ctl.scan_start)
            begin
                fmt_cnt_reg <= '0;
            end
            else if (fmt_take)
            begin
                fmt_cnt_reg <= fmt_cnt_reg + 1'b1;
            end
            if (ctl.set_formatted)
            begin
                formatted_reg <= 1'b1;
            end
            else if (ctl.clr_formatted)
            begin
                formatted_reg <= 1'b0;
            end
            if (ctl.pg_clear)
            begin
                page_cnt_reg <= '0;
            end
            else if (ctl.pg_step)
            begin
                page_cnt_reg <= page_cnt_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        stat.clr_done  = ptr_end;
        stat.scan_done = ptr_end && !pipe_vld_reg;
        stat.fmt_full  = (fmt_cnt_reg == FmtW'(nbr_pkg::USABLE_BLOCKS));
        stat.srch_hit  = srch_hit;
        stat.range_err = (lblk >= BlkW'(nbr_pkg::USABLE_BLOCKS));
        stat.formatted = formatted_reg;
        stat.pg_last   = (page_cnt_reg == '1);
        stat.out_free  = !rsp_vld_reg || rsp_ready;
    end

    assign rsp_word  = rsp_reg;
    assign rsp_valid = rsp_vld_reg;

    `NBR_ASSERT_IMPLY(a_emit_into_free, clk, rst_n,
        ctl.emit_status || ctl.emit_read || ctl.emit_move, !rsp_vld_reg || rsp_ready)
    `NBR_ASSERT_IMPLY(a_move_new_block, clk, rst_n, ctl.emit_move, new_blk_reg != old_blk_reg)
    `NBR_ASSERT_IMPLY(a_fmt_in_range, clk, rst_n, fmt_take,
        fmt_cnt_reg < FmtW'(nbr_pkg::USABLE_BLOCKS))

endmodule

`default_nettype wire

// ===== rtl/nbr_ctrl.sv =====
// ----------------------------------------------------------------------------
// nbr_ctrl
// Sequencer: table clearing, mark, format scan, read, free-block search
// and page move emission.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nand_block_remapper_defines.svh"

module nbr_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    input  wire logic [1:0]       cmd_action,
    output logic                  cmd_ready,
    input  wire nbr_pkg::dp_stat_t stat,
    output nbr_pkg::ctrl_cmd_t    ctl
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_MARK     = 4'd2;
    localparam logic [3:0] S_FMT_INIT = 4'd3;
    localparam logic [3:0] S_FMT_SCAN = 4'd4;
    localparam logic [3:0] S_CHECK    = 4'd5;
    localparam logic [3:0] S_MAP      = 4'd6;
    localparam logic [3:0] S_READ     = 4'd7;
    localparam logic [3:0] S_SRCH     = 4'd8;
    localparam logic [3:0] S_MOVE     = 4'd9;
    localparam logic [3:0] S_FREE     = 4'd10;
    localparam logic [3:0] S_TAKE     = 4'd11;
    localparam logic [3:0] S_STATUS   = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [1:0] act_reg, act_next;
    logic [1:0] err_reg, err_next;

    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        err_next   = err_reg;
        ctl        = '0;
        ctl.err    = err_reg;
        cmd_ready  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    ctl.load_in = 1'b1;
                    act_next = cmd_action;
                    unique case (cmd_action)
                        nbr_pkg::ACT_MARK:   state_next = S_MARK;
                        nbr_pkg::ACT_FORMAT: state_next = S_FMT_INIT;
                        default:             state_next = S_CHECK;
                    endcase
                end
            end
            S_MARK:
            begin
                ctl.mark_wr = 1'b1;
                err_next = nbr_pkg::ERR_OK;
                state_next = S_STATUS;
            end
            S_FMT_INIT:
            begin
                ctl.scan_start = 1'b1;
                ctl.clr_formatted = 1'b1;
                state_next = S_FMT_SCAN;
            end
            S_FMT_SCAN:
            begin
                ctl.scan_run = 1'b1;
                ctl.scan_fmt = 1'b1;
                if (stat.scan_done)
                begin
                    ctl.set_formatted = stat.fmt_full;
                    err_next = stat.fmt_full ? nbr_pkg::ERR_OK : nbr_pkg::ERR_NO_BLOCK;
                    state_next = S_STATUS;
                end
            end
            S_CHECK:
            begin
                priority if (!stat.formatted)
                begin
                    err_next = nbr_pkg::ERR_UNFORMATTED;
                    state_next = S_STATUS;
                end
                else if (stat.range_err)
                begin
                    err_next = nbr_pkg::ERR_RANGE;
                    state_next = S_STATUS;
                end
                else
                begin
                    ctl.map_rd = 1'b1;
                    state_next = S_MAP;
                end
            end
            S_MAP:
            begin
                if (act_reg == nbr_pkg::ACT_READ)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    ctl.scan_start = 1'b1;
                    state_next = S_SRCH;
                end
            end
            S_READ:
            begin
                if (stat.out_free)
                begin
                    ctl.emit_read = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SRCH:
            begin
                ctl.scan_run = 1'b1;
                ctl.scan_srch = 1'b1;
                priority if (stat.srch_hit)
                begin
                    ctl.pg_clear = 1'b1;
                    state_next = S_MOVE;
                end
                else if (stat.scan_done)
                begin
                    err_next = nbr_pkg::ERR_NO_BLOCK;
                    state_next = S_STATUS;
                end
            end
            S_MOVE:
            begin
                if (stat.out_free)
                begin
                    ctl.emit_move = 1'b1;
                    ctl.pg_step = 1'b1;
                    if (stat.pg_last)
                    begin
                        state_next = S_FREE;
                    end
                end
            end
            S_FREE:
            begin
                ctl.free_old = 1'b1;
                state_next = S_TAKE;
            end
            S_TAKE:
            begin
                ctl.take_new = 1'b1;
                state_next = S_IDLE;
            end
            S_STATUS:
            begin
                if (stat.out_free)
                begin
                    ctl.emit_status = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            act_reg   <= nbr_pkg::ACT_MARK;
            err_reg   <= nbr_pkg::ERR_OK;
        end
        else
        begin
            state_reg <= state_next;
            act_reg   <= act_next;
            err_reg   <= err_next;
        end
    end

    `NBR_ASSERT_IMPLY(a_ready_only_idle, clk, rst_n, cmd_ready, state_reg == S_IDLE)
    `NBR_ASSERT_NEXT(a_move_follows_hit, clk, rst_n,
        state_reg == S_SRCH && stat.srch_hit, state_reg == S_MOVE)
    `NBR_ASSERT_IMPLY(a_read_formatted, clk, rst_n, ctl.emit_read, stat.formatted)

endmodule

`default_nettype wire

// ===== rtl/nand_block_remapper.sv =====
// Mark writes the bad-block table; read checks format and range, then reads the map;
// format scans every table entry; each emits a result word. Write: after those checks, a
// free-block scan reads one table entry per cycle through the registered read, then 64
// page moves go out, one per cycle while the output is free, and the tables are updated.
// Items are taken one at a time; a finished word waits in the result register under stall.
// After reset the bad and used tables are cleared one entry per cycle, then ready rises.
// ----------------------------------------------------------------------------
// nand_block_remapper
// Block-mapping NAND translation layer: bad-block marking, table format,
// sector read translation and block rewrite as page move commands.
// ----------------------------------------------------------------------------
`default_nettype none

module nand_block_remapper (
    input  wire logic clk,
    input  wire logic rst_n,
    nbr_cmd_if.sink   cmd,
    nbr_rsp_if.source rsp
);

    nbr_pkg::ctrl_cmd_t ctl;
    nbr_pkg::dp_stat_t  stat;

    nbr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd.valid),
        .cmd_action (cmd.payload.action),
        .cmd_ready  (cmd.ready),
        .stat       (stat),
        .ctl        (ctl)
    );

    nbr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_word  (cmd.payload),
        .ctl       (ctl),
        .stat      (stat),
        .rsp_word  (rsp.payload),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready)
    );

endmodule

`default_nettype wire
